// ----- hdl/ais_pkg.sv -----
// ais_pkg: shared types for the ascending integer sorter
// request payloads, cell control and neighbor link structs; no dependencies
`timescale 1ns / 1ps

package ais_pkg;

  localparam int unsigned DataW = 32;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    final_res;
    logic                    overflowed;
  } out_item_t;

  // broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    shl;
    logic signed [DataW-1:0] x;
  } cell_ctl_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic                    valid;
    logic                    gt;
    logic signed [DataW-1:0] value;
  } cell_link_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

// ----- hdl/ais_stream_if.sv -----
// ais_stream_if: valid/ready channel carrying one request payload
// payload type is a parameter; uses ais_pkg types at instantiation
`timescale 1ns / 1ps

interface ais_stream_if #(
  parameter type T = logic
) (
  input logic clk
);
  logic valid;
  logic ready;
  T     data;

  modport source (input clk, output valid, output data, input ready);
  modport sink   (input clk, input valid, input data, output ready);
endinterface

// ----- hdl/ais_cell.sv -----
// ais_cell: one slot of the insertion chain, holds one value and a valid bit
// depends on ais_pkg (cell_ctl_t, cell_link_t)
`timescale 1ns / 1ps

module ais_cell (
  input  logic               clk,
  input  logic               rst,
  input  ais_pkg::cell_ctl_t ctl,
  input  ais_pkg::cell_link_t left,
  input  ais_pkg::cell_link_t right,
  output ais_pkg::cell_link_t own
);

  logic                            valid;
  logic signed [ais_pkg::DataW-1:0] value;

  // empty slots act as +infinity
  assign own.valid = valid;
  assign own.value = value;
  assign own.gt    = !valid || (value > ctl.x);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ins && own.gt) begin
      if (left.gt) begin
        valid <= left.valid;
      end else begin
        valid <= 1'b1;
      end
    end else if (ctl.shl) begin
      valid <= right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && own.gt) begin
      if (left.gt) begin
        value <= left.value;
      end else begin
        value <= ctl.x;
      end
    end else if (ctl.shl) begin
      value <= right.value;
    end
  end

endmodule

// ----- hdl/ascending_integer_sorter.sv -----
// ascending_integer_sorter: top level, chain of ais_cell slots plus load/drain control
// depends on ais_pkg, ais_stream_if, ais_cell
//
// Usage: values arrive on the item channel (value, last). Each accepted request
// is inserted into a sorted chain of MAX_ELEMENTS cells as it is accepted, or
// dropped if the chain is full. The request with last = 1 closes the set;
// from the next cycle the block drains, showing the smallest held value on the
// result channel and shifting the chain by one cell per accepted result.
// final_res marks the largest value, overflowed is set on every result of a
// set in which values beyond MAX_ELEMENTS were dropped.
// For a set, the first result comes in the cycle after the closing request,
// then one result per cycle while the receiver takes them.
// item.ready is low while draining; a stall on the result channel holds the
// chain and the current result unchanged. The drain ends on the accepted result
// with final_res, which is set while the cell behind the head is empty.
// Reset (rst, synchronous) empties every cell and clears the count and
// overflow flag; the block comes up ready for a new set.
`timescale 1ns / 1ps

module ascending_integer_sorter #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input logic            clk,
  input logic            rst,
  ais_stream_if.sink     item,
  ais_stream_if.source   result
);

  localparam int unsigned CntW = $clog2(MAX_ELEMENTS + 1);

  ais_pkg::state_t     state;
  logic [CntW-1:0]     count;
  logic                overflow_seen;
  logic                drain_ovf;
  logic                full;
  logic                item_acc;
  logic                res_acc;
  logic                final_now;
  ais_pkg::cell_ctl_t  ctl;
  ais_pkg::cell_link_t link [MAX_ELEMENTS];
  ais_pkg::cell_link_t edge_lo;
  ais_pkg::cell_link_t edge_hi;
  logic [MAX_ELEMENTS-1:0] valid_vec;

  assign full      = (count == CntW'(MAX_ELEMENTS));
  assign item_acc  = item.valid && item.ready;
  assign res_acc   = result.valid && result.ready;
  assign final_now = !link[1].valid;

  assign item.ready   = (state == ais_pkg::ST_LOAD);
  assign result.valid = (state == ais_pkg::ST_DRAIN);
  assign result.data.sorted_value = link[0].value;
  assign result.data.final_res    = final_now;
  assign result.data.overflowed   = drain_ovf;

  assign ctl.ins = item_acc && !full;
  assign ctl.shl = res_acc;
  assign ctl.x   = item.data.value;

  // chain ends: nothing smaller on the left, nothing on the right
  assign edge_lo.valid = 1'b1;
  assign edge_lo.gt    = 1'b0;
  assign edge_lo.value = '0;
  assign edge_hi.valid = 1'b0;
  assign edge_hi.gt    = 1'b1;
  assign edge_hi.value = '0;

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    ais_pkg::cell_link_t l_in;
    ais_pkg::cell_link_t r_in;
    if (i == 0) begin : g_lo
      assign l_in = edge_lo;
    end else begin : g_lm
      assign l_in = link[i-1];
    end
    if (i == MAX_ELEMENTS - 1) begin : g_hi
      assign r_in = edge_hi;
    end else begin : g_rm
      assign r_in = link[i+1];
    end
    ais_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .left  (l_in),
      .right (r_in),
      .own   (link[i])
    );
    assign valid_vec[i] = link[i].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ais_pkg::ST_LOAD;
      count         <= '0;
      overflow_seen <= 1'b0;
      drain_ovf     <= 1'b0;
    end else begin
      case (state)
        ais_pkg::ST_LOAD: begin
          if (item_acc) begin
            if (full) begin
              overflow_seen <= 1'b1;
            end else begin
              count <= count + 1'b1;
            end
            if (item.data.last) begin
              state         <= ais_pkg::ST_DRAIN;
              drain_ovf     <= overflow_seen || full;
              overflow_seen <= 1'b0;
            end
          end
        end
        ais_pkg::ST_DRAIN: begin
          if (res_acc && final_now) begin
            state <= ais_pkg::ST_LOAD;
            count <= '0;
          end
        end
        default: begin
          state <= ais_pkg::ST_LOAD;
        end
      endcase
    end
  end

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ais_pkg::ST_DRAIN |-> link[0].valid)
    else $error("draining with an empty chain head");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    state == ais_pkg::ST_LOAD |-> $countones(valid_vec) == 32'(count))
    else $error("occupied cells disagree with count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= MAX_ELEMENTS)
    else $error("count beyond capacity");

  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    res_acc && final_now |=> state == ais_pkg::ST_LOAD && !link[0].valid)
    else $error("chain not empty after final result");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    item_acc && item.data.last |=> state == ais_pkg::ST_DRAIN)
    else $error("closing request did not start drain");

endmodule
